// File: rtl/swa_pkg.sv
// Shared constants and types for the sliding window average block.
// No dependencies; imported by swa_div and sliding_window_average.
package swa_pkg;

  // Ring depth and sample width
  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;

  // Derived widths
  localparam int POS_BITS = $clog2(WINDOW_MAX);
  localparam int LEN_BITS = 7;                      // window_length register
  localparam int SUM_BITS = SAMPLE_BITS + POS_BITS; // sum of the whole ring
  localparam int CNT_BITS = $clog2(SUM_BITS);

  // Reset value of window_length
  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(16);

  // Divider status toward the sequencer
  typedef struct packed {
    logic                done;  // one-cycle pulse, quotient ready
    logic                neg;   // quotient is negative
    logic [SUM_BITS-1:0] quo;   // quotient magnitude
  } div_res_t;

endpackage

// File: rtl/swa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/swa_div.sv
// Restoring divider: signed running sum by unsigned window length,
// one quotient bit per cycle. Depends on swa_pkg.
module swa_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [swa_pkg::SUM_BITS-1:0]   dividend_i,
  input  logic        [swa_pkg::LEN_BITS-1:0]   divisor_i,
  output swa_pkg::div_res_t                     res_o
);
  import swa_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic [SUM_BITS-1:0] mag_q;
  logic [LEN_BITS-1:0] rem_q;
  logic                neg_q;

  logic [LEN_BITS:0]   shifted;
  logic [LEN_BITS:0]   diff;
  logic                fits;
  logic [LEN_BITS-1:0] rem_d;
  logic [SUM_BITS-1:0] dividend_abs;

  // One restoring step
  always_comb begin
    shifted      = {rem_q, mag_q[SUM_BITS-1]};
    fits         = shifted >= {1'b0, divisor_i};
    diff         = shifted - {1'b0, divisor_i};
    rem_d        = fits ? diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
    dividend_abs = dividend_i[SUM_BITS-1] ? SUM_BITS'(-dividend_i)
                                          : SUM_BITS'(dividend_i);
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(SUM_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out the top, quotient bits shift in below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= dividend_abs;
      rem_q <= '0;
      neg_q <= dividend_i[SUM_BITS-1];
    end else if (busy_q) begin
      mag_q <= {mag_q[SUM_BITS-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.neg  = neg_q;
  assign res_o.quo  = mag_q;

endmodule

// File: rtl/sliding_window_average.sv
// Sliding window average: top level with sequencer, ring RAM and divider.
// Depends on swa_pkg, swa_ram and swa_div.
//
// Usage:
//   Samples enter on the s_axis channel, one signed sample per transfer.
//   Each sample replaces the oldest ring entry at the write position, the
//   running sum is updated, and the average (sum / window length, toward
//   zero, saturated to the sample range) leaves on the m_axis channel.
//   window_length is written through cfg_valid_i/cfg_data_i while idle;
//   cfg_ready_o is low while a sample is in progress.
//   0 acts as 1 and values above the ring depth act as the ring depth.
// Processing:
//   A result passes through the sum update, the divider load, SUM_BITS
//   restoring steps, the done flag and then the output register. The
//   shared one-bit-per-cycle divider sets the rate; s_axis_tready is low
//   from acceptance until the result reaches the output register, so a
//   new sample is taken only once the previous result has been loaded.
// Reset:
//   Ring reads as zero (per-entry valid bits), sum and position clear,
//   window_length returns to 16. No clearing pass is needed.
// Stalls:
//   A result waits in the output register while m_axis_tready is low; the
//   next sample is still taken and processed, and holds before the output
//   register until the previous result has been transferred.
module sliding_window_average (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [swa_pkg::LEN_BITS-1:0] cfg_data_i,     // [6:0] window_length
  // Sample input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [swa_pkg::SAMPLE_BITS-1:0] s_axis_tdata, // [15:0] sample
  // Average output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [swa_pkg::SAMPLE_BITS-1:0] m_axis_tdata  // [15:0] average
);
  import swa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE,
    ST_OUT
  } state_e;

  state_e                     state_q;
  logic [LEN_BITS-1:0]        len_cfg_q;
  logic [POS_BITS-1:0]        pos_q;
  logic signed [SUM_BITS-1:0] sum_q;
  logic [SAMPLE_BITS-1:0]     sample_q;
  logic [WINDOW_MAX-1:0]      vld_q;
  logic                       m_valid_q;
  logic [SAMPLE_BITS-1:0]     m_data_q;

  logic [LEN_BITS-1:0]        eff_len;
  logic [POS_BITS:0]          pos_inc;
  logic [POS_BITS-1:0]        pos_d;
  logic [SAMPLE_BITS-1:0]     ram_rdata;
  logic [SAMPLE_BITS-1:0]     old_sample;
  logic signed [SUM_BITS-1:0] sum_d;
  logic                       s_xfer;
  logic                       ram_we;
  logic                       div_start;
  div_res_t                   div_res;
  logic [SAMPLE_BITS-1:0]     avg_sat;
  logic                       out_free;

  // Length changes only between samples; the divider reads it live
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign ram_we        = (state_q == ST_UPDATE);
  assign div_start     = (state_q == ST_START);

  // Effective window length and next write position
  always_comb begin
    if (len_cfg_q == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (32'(len_cfg_q) > WINDOW_MAX) begin
      eff_len = LEN_BITS'(WINDOW_MAX);
    end else begin
      eff_len = len_cfg_q;
    end
    pos_inc = {1'b0, pos_q} + 1'b1;
    if (32'(pos_inc) >= 32'(eff_len) || 32'(pos_inc) >= WINDOW_MAX) begin
      pos_d = '0;
    end else begin
      pos_d = pos_inc[POS_BITS-1:0];
    end
  end

  // Running sum update; unwritten ring entries read as zero
  always_comb begin
    old_sample = vld_q[pos_q] ? ram_rdata : '0;
    sum_d = sum_q
          - {{POS_BITS{old_sample[SAMPLE_BITS-1]}}, old_sample}
          + {{POS_BITS{sample_q[SAMPLE_BITS-1]}}, sample_q};
  end

  // Saturate the signed quotient to the sample range
  always_comb begin
    if (div_res.neg) begin
      if (div_res.quo > SUM_BITS'(2 ** (SAMPLE_BITS - 1))) begin
        avg_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
        avg_sat = SAMPLE_BITS'(-div_res.quo);
      end
    end else begin
      if (div_res.quo > SUM_BITS'(2 ** (SAMPLE_BITS - 1) - 1)) begin
        avg_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
        avg_sat = div_res.quo[SAMPLE_BITS-1:0];
      end
    end
  end

  // Ring storage; read address follows the write position
  swa_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WINDOW_MAX)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q),
    .wdata_i(sample_q),
    .raddr_i(pos_q),
    .rdata_o(ram_rdata)
  );

  // Shared divider
  swa_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (eff_len),
    .res_o     (div_res)
  );

  // Sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_cfg_q <= LEN_RESET;
      pos_q     <= '0;
      sum_q     <= '0;
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        len_cfg_q <= cfg_data_i;
      end
      // A load in ST_OUT takes precedence over the clear
      if (m_valid_q && m_axis_tready && state_q != ST_OUT) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_xfer) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          sum_q        <= sum_d;
          vld_q[pos_q] <= 1'b1;
          pos_q        <= pos_d;
          state_q      <= ST_START;
        end
        ST_START: begin
          state_q <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_res.done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      sample_q <= s_axis_tdata;
    end
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= avg_sat;
    end
  end

  // Divider finishes only while the sequencer waits for it
  a_div_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> state_q == ST_DIVIDE)
    else $error("divider finished outside the divide state");

  // An accepted sample moves straight to the sum update
  a_accept_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> state_q == ST_UPDATE)
    else $error("accepted sample did not reach the update state");

  // A new result is loaded only when the output register is free
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && m_valid_q && !m_axis_tready) |=> state_q == ST_OUT)
    else $error("result loaded over an untransferred one");

endmodule
